// File: rtl/core/trie_prefix_conflict_checker_top_macros.svh
// Assertion helpers for the prefix conflict checker.
`ifndef TRIE_PREFIX_CONFLICT_CHECKER_TOP_MACROS_SVH
`define TRIE_PREFIX_CONFLICT_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TPCC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpcc assertion failed");

// Next-cycle implication, checked outside reset.
`define TPCC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpcc assertion failed");

`endif

// File: rtl/core/tpcc_pkg.sv
`default_nettype none
package tpcc_pkg;
   localparam int DIGIT_W        = 4;
   localparam int DEF_NODE_COUNT = 4096;
   localparam int DEF_RADIX      = 10;
endpackage
`default_nettype wire

// File: rtl/core/tpcc_if.sv
`default_nettype none
// Digit channel.
interface tpcc_req_if import tpcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DIGIT_W-1:0] digit;
   logic               last_of_number;
   logic               first_of_list;

   modport source (output valid, output digit, output last_of_number,
                   output first_of_list, input ready);
   modport sink   (input valid, input digit, input last_of_number,
                   input first_of_list, output ready);
endinterface

// Per-number result channel.
interface tpcc_rsp_if ();
   logic valid;
   logic ready;
   logic conflict;
   logic pool_full;

   modport source (output valid, output conflict, output pool_full, input ready);
   modport sink   (input valid, input conflict, input pool_full, output ready);
endinterface
`default_nettype wire

// File: rtl/core/tpcc_node_ram.sv
`default_nettype none
// Single-port-style node row store: one write and one registered read per cycle.
module tpcc_node_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 130
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/core/trie_prefix_conflict_checker_top.sv
// Channel | Dir | Modport | Beat contents
// req_bus | in  | sink    | digit, last_of_number, first_of_list
// rsp_bus | out | source  | conflict, pool_full (one beat per number)
//
// A digit is handled in ST_IDLE, whose accept cycle reads the cursor node's row,
// then in ST_LOOK, the next cycle, which inspects the child entry. A digit
// that allocates a node then passes through ST_CLEAR, which writes the new
// node's row as all null. New digits are taken only in ST_IDLE.
// Reset is synchronous; no clearing pass: rows are cleared as nodes are
// allocated, and the root row reads as null until first written in a list.
// A number's last digit waits while the result register is still full.
`default_nettype none
`include "trie_prefix_conflict_checker_top_macros.svh"
module trie_prefix_conflict_checker_top import tpcc_pkg::*; #(
   parameter int NODE_COUNT = DEF_NODE_COUNT,
   parameter int RADIX      = DEF_RADIX
) (
   input wire logic   clock,
   input wire logic   reset,
   tpcc_req_if.sink   req_bus,
   tpcc_rsp_if.source rsp_bus
);
   localparam int IDW = $clog2(NODE_COUNT);   // node id width
   localparam int NFW = IDW + 1;              // free counter, holds NODE_COUNT
   localparam int EW  = IDW + 1;              // child entry: {end mark, id}
   localparam int RW  = RADIX * EW;           // one row per node
   localparam int DSW = $clog2(RADIX);        // digit select width
   localparam logic [DIGIT_W:0] RADIX_V   = (DIGIT_W + 1)'(RADIX);
   localparam logic [NFW-1:0]   POOL_SIZE = NFW'(NODE_COUNT);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;  // wait for a digit, issue row read
   localparam logic [1:0] ST_LOOK  = 2'd1;  // row data back, walk or allocate
   localparam logic [1:0] ST_CLEAR = 2'd2;  // null out the new node's row
   localparam logic [1:0] ST_HOLD  = 2'd3;  // result waits for the output slot

   logic [1:0]         state_ff, state_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic               last_ff, last_in;
   logic [IDW-1:0]     cursor_ff, cursor_in;
   logic [NFW-1:0]     next_free_ff, next_free_in;
   logic               all_existed_ff, all_existed_in;
   logic               stopped_ff, stopped_in;
   logic               conflict_ff, conflict_in;
   logic               pool_ff, pool_in;
   logic               root_null_ff, root_null_in;   // row 0 stale, read as null
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_conflict_ff, rsp_conflict_in;
   logic               rsp_full_ff, rsp_full_in;

   logic               mem_rd_en;
   logic [IDW-1:0]     mem_rd_addr;
   logic [RW-1:0]      mem_rd_data;
   logic               mem_wr_en;
   logic [IDW-1:0]     mem_wr_addr;
   logic [RW-1:0]      mem_wr_data;

   logic               accept;
   logic               slot_free;
   logic               active;
   logic               finish;
   logic               rsp_load;
   logic [DSW-1:0]     dsel;
   logic [RW-1:0]      row_eff;
   logic [RW-1:0]      row_upd;
   logic [EW-1:0]      entry;
   logic [IDW-1:0]     child_id;
   logic               child_end;

   tpcc_node_ram #(
      .DEPTH(NODE_COUNT),
      .WIDTH(RW)
   ) u_node_ram (
      .clock  (clock),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data)
   );

   assign accept    = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.conflict  = rsp_conflict_ff;
   assign rsp_bus.pool_full = rsp_full_ff;

   // Row as seen this list: root row is null until written after a list start.
   assign row_eff   = (root_null_ff && (cursor_ff == '0)) ? '0 : mem_rd_data;
   assign dsel      = digit_ff[DSW-1:0];
   assign entry     = row_eff[dsel*EW +: EW];
   assign child_id  = entry[IDW-1:0];
   assign child_end = entry[IDW];
   assign active    = !conflict_ff && !stopped_ff && ({1'b0, digit_ff} < RADIX_V);

   always_comb begin
      row_upd = row_eff;
      row_upd[dsel*EW +: EW] = {last_ff, next_free_ff[IDW-1:0]};
   end

   always_comb begin
      state_in        = state_ff;
      digit_in        = digit_ff;
      last_in         = last_ff;
      cursor_in       = cursor_ff;
      next_free_in    = next_free_ff;
      all_existed_in  = all_existed_ff;
      stopped_in      = stopped_ff;
      conflict_in     = conflict_ff;
      pool_in         = pool_ff;
      root_null_in    = root_null_ff;
      rsp_conflict_in = rsp_conflict_ff;
      rsp_full_in     = rsp_full_ff;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = cursor_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = cursor_ff;
      mem_wr_data     = row_upd;
      finish          = 1'b0;
      rsp_load        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               digit_in  = req_bus.digit;
               last_in   = req_bus.last_of_number;
               mem_rd_en = 1'b1;
               if (req_bus.first_of_list) begin
                  // new list: empty trie, fresh flags
                  mem_rd_addr    = '0;
                  cursor_in      = '0;
                  next_free_in   = NFW'(1);
                  all_existed_in = 1'b1;
                  stopped_in     = 1'b0;
                  conflict_in    = 1'b0;
                  pool_in        = 1'b0;
                  root_null_in   = 1'b1;
               end
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            finish = 1'b1;
            if (active) begin
               if (child_id != '0) begin
                  cursor_in = child_id;
                  if (child_end) begin
                     stopped_in = 1'b1;
                  end
               end else begin
                  all_existed_in = 1'b0;
                  if (next_free_ff == POOL_SIZE) begin
                     pool_in    = 1'b1;
                     stopped_in = 1'b1;
                  end else begin
                     // link the new node into the parent row
                     mem_wr_en    = 1'b1;
                     cursor_in    = next_free_ff[IDW-1:0];
                     next_free_in = next_free_ff + NFW'(1);
                     if (cursor_ff == '0) begin
                        root_null_in = 1'b0;
                     end
                     finish   = 1'b0;
                     state_in = ST_CLEAR;
                  end
               end
            end
         end
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = '0;
            finish      = 1'b1;
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         priority if (!last_ff) begin
            state_in = ST_IDLE;
         end else if (slot_free) begin
            rsp_load = 1'b1;
            state_in = ST_IDLE;
         end else begin
            state_in = ST_HOLD;
         end
      end

      if (rsp_load) begin
         // a number that built no node is a prefix of an earlier one
         conflict_in     = conflict_in || all_existed_in;
         rsp_conflict_in = conflict_in;
         rsp_full_in     = pool_in;
         cursor_in       = '0;
         all_existed_in  = 1'b1;
         stopped_in      = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cursor_ff      <= '0;
         next_free_ff   <= NFW'(1);
         all_existed_ff <= 1'b1;
         stopped_ff     <= 1'b0;
         conflict_ff    <= 1'b0;
         pool_ff        <= 1'b0;
         root_null_ff   <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cursor_ff      <= cursor_in;
         next_free_ff   <= next_free_in;
         all_existed_ff <= all_existed_in;
         stopped_ff     <= stopped_in;
         conflict_ff    <= conflict_in;
         pool_ff        <= pool_in;
         root_null_ff   <= root_null_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      digit_ff        <= digit_in;
      last_ff         <= last_in;
      rsp_conflict_ff <= rsp_conflict_in;
      rsp_full_ff     <= rsp_full_in;
   end

   // cursor always names a node allocated in the current list
   `TPCC_ASSERT_IMP(a_cursor_alloc, clock, reset, 1'b1, {1'b0, cursor_ff} < next_free_ff)
   // the row clear cycle only follows a parent link write
   `TPCC_ASSERT_IMP(a_clear_after_link, clock, reset, state_ff == ST_CLEAR,
                    $past(mem_wr_en && (state_ff == ST_LOOK)))
   // sequencer never reads and writes the row memory in one cycle
   `TPCC_ASSERT_IMP(a_no_rw_overlap, clock, reset, mem_wr_en, !mem_rd_en)
   // a loaded result stays offered until taken
   `TPCC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_bus.ready,
                    rsp_valid_ff && $stable(rsp_conflict_ff) && $stable(rsp_full_ff))
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none
module tb;
   import tpcc_pkg::*;

   localparam int NODES  = DEF_NODE_COUNT;
   localparam int DIGITS = DEF_RADIX;

   // One digit beat as queued for the driver; hold_for_drain makes the
   // driver wait until every outstanding verdict has come back first.
   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               last_of_number;
      logic               first_of_list;
      logic               hold_for_drain;
   } digit_beat_type;

   // Per-number verdict as returned on the result channel.
   typedef struct packed {
      logic conflict;
      logic pool_full;
   } verdict_type;

   logic clock;
   logic reset;

   tpcc_req_if req_bus ();
   tpcc_rsp_if rsp_bus ();

   trie_prefix_conflict_checker_top #(
      .NODE_COUNT(NODES),
      .RADIX     (DIGITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   digit_beat_type beats_to_send [$];
   verdict_type    verdicts_due [$];
   int             fail_count = 0;

   // ---------------------------------------------------------------
   // Trie shadow: sparse copy of the child table and end marks.
   // Missing keys read as null / unmarked, so a list clear is a delete.
   // ---------------------------------------------------------------
   int unsigned trie_child [int unsigned];
   bit          trie_end   [int unsigned];
   int unsigned walk_node;
   int unsigned free_node;
   bit          walk_all_old;   // no node created by this number yet
   bit          walk_halted;    // number stopped at an end mark / full pool
   bit          list_conflict;
   bit          list_full;

   function automatic void restart_walk();
      walk_node    = 0;
      walk_all_old = 1'b1;
      walk_halted  = 1'b0;
   endfunction

   function automatic void clear_trie();
      trie_child.delete();
      trie_end.delete();
      free_node     = 1;
      list_conflict = 1'b0;
      list_full     = 1'b0;
      restart_walk();
   endfunction

   // Advance the shadow trie by one accepted digit beat; a verdict is
   // queued on the last digit of each number.
   function automatic void walk_digit(digit_beat_type b);
      int unsigned key;
      int unsigned kid;
      verdict_type v;
      if (b.first_of_list)
         clear_trie();
      if (!list_conflict && !walk_halted && b.digit < DIGITS && walk_node < NODES) begin
         key = walk_node * DIGITS + b.digit;
         kid = trie_child.exists(key) ? trie_child[key] : 0;
         if (kid == 0) begin
            walk_all_old = 1'b0;
            if (free_node >= NODES) begin
               list_full   = 1'b1;
               walk_halted = 1'b1;
            end else begin
               trie_child[key]     = free_node;
               trie_end[free_node] = b.last_of_number;
               walk_node           = free_node;
               free_node++;
            end
         end else if (kid < NODES) begin
            walk_node = kid;
            if (trie_end.exists(kid) && trie_end[kid])
               walk_halted = 1'b1;
         end else begin
            walk_halted = 1'b1;
         end
      end
      if (b.last_of_number) begin
         // a number that built no node is a prefix of (or equal to) another
         if (!list_conflict && walk_all_old)
            list_conflict = 1'b1;
         v.conflict  = list_conflict;
         v.pool_full = list_full;
         verdicts_due.push_back(v);
         restart_walk();
      end
   endfunction

   // Idle length: mostly zero or short, now and then long; a quiet stretch
   // forces back-to-back traffic for a while.
   function automatic int idle_len(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 99) == 0)
         quiet = $urandom_range(20, 80);
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // ---------------------------------------------------------------
   // Clock, time-zero input values, watchdog.
   // ---------------------------------------------------------------
   initial begin
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.digit          = '0;
      req_bus.last_of_number = 1'b0;
      req_bus.first_of_list  = 1'b0;
      rsp_bus.ready          = 1'b0;
      forever #5 clock = ~clock;
   end

   // Worst case is roughly 5200 beats, each with its busy time, the longest
   // gap and the longest stall; this allows several times that.
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------
   // Driver: pops beats, inserts random gaps, honors drain holds.
   // Prediction happens here, at the edge where the beat is taken.
   // ---------------------------------------------------------------
   digit_beat_type on_bus;
   int             send_gap   = 0;
   int             send_quiet = 0;

   always @(posedge clock) begin
      logic go;
      if (reset) begin
         req_bus.valid          <= 1'b0;
         req_bus.digit          <= '0;
         req_bus.last_of_number <= 1'b0;
         req_bus.first_of_list  <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            walk_digit(on_bus);
         if (!req_bus.valid || req_bus.ready) begin
            go = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (beats_to_send.size() > 0 &&
                         !(beats_to_send[0].hold_for_drain && verdicts_due.size() > 0)) begin
               on_bus = beats_to_send.pop_front();
               go     = 1'b1;
               req_bus.digit          <= on_bus.digit;
               req_bus.last_of_number <= on_bus.last_of_number;
               req_bus.first_of_list  <= on_bus.first_of_list;
               send_gap = idle_len(send_quiet);
            end
            req_bus.valid <= go;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random backpressure, in-order verdict check.
   // ---------------------------------------------------------------
   int take_gap   = 0;
   int take_quiet = 0;

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: unexpected beat: conflict=%0b pool_full=%0b",
                        $time, rsp_bus.conflict, rsp_bus.pool_full);
               fail_count++;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_bus.conflict !== want.conflict) begin
                  $display("%0t: conflict mismatch: expected %0b, got %0b",
                           $time, want.conflict, rsp_bus.conflict);
                  fail_count++;
               end
               if (rsp_bus.pool_full !== want.pool_full) begin
                  $display("%0t: pool_full mismatch: expected %0b, got %0b",
                           $time, want.pool_full, rsp_bus.pool_full);
                  fail_count++;
               end
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            take_gap = idle_len(take_quiet);
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus builders.
   // ---------------------------------------------------------------

   // Queue one number, digits packed low nibble first.
   task automatic queue_number(bit [31:0] digs, int len, bit starts_list, bit drain);
      digit_beat_type b;
      for (int j = 0; j < len; j++) begin
         b.digit          = digs[4*j +: 4];
         b.last_of_number = (j == len - 1);
         b.first_of_list  = starts_list && (j == 0);
         b.hold_for_drain = drain && (j == 0);
         beats_to_send.push_back(b);
      end
   endtask

   function automatic bit [3:0] rand_digit();
      if ($urandom_range(0, 99) < 3)
         return 4'($urandom_range(DIGITS, 15));
      return 4'($urandom_range(0, DIGITS - 1));
   endfunction

   // One well-formed list: numbers that repeat, extend, cut short or branch
   // off earlier ones, so that both clean and conflicting lists show up.
   task automatic queue_list();
      bit [31:0] seen_digs [$];
      int        seen_len  [$];
      bit [31:0] v;
      int        len, n, k, m, pick;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < 8; j++)
            v[4*j +: 4] = rand_digit();
         len  = $urandom_range(1, 6);
         pick = $urandom_range(0, 9);
         if (seen_digs.size() > 0 && pick < 5) begin
            k = $urandom_range(0, seen_digs.size() - 1);
            if (pick == 0) begin
               // prefix of an earlier number (or the same number)
               v   = seen_digs[k];
               len = $urandom_range(1, seen_len[k]);
            end else if (pick == 1) begin
               // earlier number extended
               for (int j = 0; j < seen_len[k]; j++)
                  v[4*j +: 4] = seen_digs[k][4*j +: 4];
               len = seen_len[k] + $urandom_range(0, 2);
               if (len > 8)
                  len = 8;
            end else begin
               // shared prefix, then a different digit
               m = $urandom_range(0, seen_len[k] - 1);
               for (int j = 0; j < m; j++)
                  v[4*j +: 4] = seen_digs[k][4*j +: 4];
               v[4*m +: 4] = 4'((seen_digs[k][4*m +: 4] + $urandom_range(1, DIGITS - 1))
                                % DIGITS);
               if (len < m + 1)
                  len = m + 1;
            end
         end
         seen_digs.push_back(v);
         seen_len.push_back(len);
         queue_number(v, len, i == 0, i == 0 && $urandom_range(0, 49) == 0);
      end
   endtask

   // Free-form beats: any digit, any flag.
   task automatic queue_noise();
      digit_beat_type b;
      int             n;
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
         b.digit          = 4'($urandom_range(0, 15));
         b.last_of_number = 1'($urandom_range(0, 1));
         b.first_of_list  = ($urandom_range(0, 7) == 0);
         b.hold_for_drain = 1'b0;
         beats_to_send.push_back(b);
      end
   endtask

   // One number longer than the node pool: every digit allocates until the
   // pool runs dry, then a few short numbers in the same list.
   task automatic queue_pool_overflow();
      digit_beat_type b;
      bit [3:0]       lead;
      lead = 4'($urandom_range(0, DIGITS - 1));
      for (int j = 0; j < NODES + 4; j++) begin
         b.digit          = (j == 0) ? lead : 4'($urandom_range(0, DIGITS - 1));
         b.last_of_number = (j == NODES + 3);
         b.first_of_list  = (j == 0);
         b.hold_for_drain = (j == 0);
         beats_to_send.push_back(b);
      end
      queue_number(32'($urandom_range(0, DIGITS - 1)), 1, 1'b0, 1'b0);
      queue_number({28'h0, lead}, 1, 1'b0, 1'b0);
      queue_number(32'h0000_0321, 3, 1'b0, 1'b0);
   endtask

   // ---------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------
   initial begin
      bit overflow_done;
      overflow_done = 1'b0;

      // Directed: clean list, then a repeat prefix makes it sticky.
      queue_number(32'h0000_0021, 2, 1'b1, 1'b0);   // 12
      queue_number(32'h0000_0809, 3, 1'b0, 1'b0);   // 908
      queue_number(32'h0000_0001, 1, 1'b0, 1'b0);   // 1: prefix of 12
      queue_number(32'h0000_0765, 3, 1'b0, 1'b0);   // ignored after conflict
      // New list: walking into an end-marked node stops the number.
      queue_number(32'h0000_0009, 1, 1'b1, 1'b0);   // 9
      queue_number(32'h0000_0089, 2, 1'b0, 1'b0);   // 98
      // Out-of-range digits leave the trie alone; alone they make a conflict.
      queue_number(32'h0000_000A, 2, 1'b1, 1'b0);   // A,0
      queue_number(32'h0000_000F, 1, 1'b0, 1'b0);   // F alone
      // Branching siblings, no conflict.
      queue_number(32'h0000_0054, 2, 1'b1, 1'b0);   // 45
      queue_number(32'h0000_0064, 2, 1'b0, 1'b0);   // 46
      // New list raised in the middle of a number.
      queue_number(32'h0000_0007, 1, 1'b0, 1'b0)  ; // never ends: see next beat
      beats_to_send[$].last_of_number = 1'b0;
      queue_number(32'h0000_0007, 1, 1'b1, 1'b0);   // 7 with list start

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Random part; a drain hold is set on the first queued beat that starts a list.
      queue_list();
      beats_to_send[beats_to_send.size() - 1].hold_for_drain = 1'b0;
      while (beats_to_send.size() + 20 < 1000) begin
         if (!overflow_done && beats_to_send.size() > 400) begin
            queue_pool_overflow();
            overflow_done = 1'b1;
         end
         if ($urandom_range(0, 9) == 0)
            queue_noise();
         else
            queue_list();
      end
      for (int i = 0; i < beats_to_send.size(); i++)
         if (beats_to_send[i].first_of_list) begin
            beats_to_send[i].hold_for_drain = 1'b1;
            break;
         end
      if (!overflow_done)
         queue_pool_overflow();

      while (beats_to_send.size() > 0 || req_bus.valid)
         @(posedge clock);
      while (verdicts_due.size() > 0)
         @(posedge clock);
      repeat (12) @(posedge clock);

      if (fail_count == 0 && verdicts_due.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire
